>>> sv/lpas_pkg.sv
// ---------------------------------------------------------------------------
// lpas_pkg
// Shared widths, operation codes and the scan result type of the linear
// action selector.
// ---------------------------------------------------------------------------
`default_nettype none

package lpas_pkg;

    localparam int W_W    = 16;  // Q8.8 weight and feature
    localparam int PROD_W = 32;  // Q16.16 product
    localparam int ACC_W  = 40;  // Q24.16 score
    localparam int DIFF_W = 41;  // score difference, one bit of growth
    localparam int ACT_W  = 3;   // action index and tie count
    localparam int POS_W  = 5;   // feature position, 0 to 16
    localparam int SLOT_W = 6;   // weight table slot
    localparam int ADDR_W = 7;   // slot address before the range check
    localparam int TOL_W  = 16;
    localparam int RND_W  = 64;
    localparam int SLICE_W = 16;

    localparam int DEPTH = 64;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [ACC_W-1:0] score;
        logic [ACT_W-1:0]        ties;
    } scan_res_t;

endpackage

`default_nettype wire

>>> sv/lpas_cell.sv
// ---------------------------------------------------------------------------
// lpas_cell
// One score accumulator of the ring. On shift it takes its neighbor's score
// plus an addend.
// ---------------------------------------------------------------------------
`default_nettype none

module lpas_cell
    import lpas_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    shift,
    input  wire logic signed [ACC_W-1:0] nbr_in,
    input  wire logic signed [ACC_W-1:0] addend,
    output logic signed [ACC_W-1:0]      acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (shift)
        begin
            acc_next = nbr_in + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

>>> sv/lpas_weight_mac.sv
// ---------------------------------------------------------------------------
// lpas_weight_mac
// Weight table with one write and one registered read port, followed by a
// registered feature times weight multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module lpas_weight_mac
    import lpas_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [SLOT_W-1:0]        wr_slot,
    input  wire logic [W_W-1:0]           wr_data,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    input  wire logic signed [W_W-1:0]    feature,
    output logic signed [PROD_W-1:0]      prod,
    output logic                          prod_valid
);

    logic [W_W-1:0]            mem [DEPTH];
    logic [W_W-1:0]            rdata_reg;
    logic                      oob_reg;
    logic                      rd_valid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr[SLOT_W-1:0]];
            // slots past the table read as zero
            oob_reg   <= rd_addr[ADDR_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            if (oob_reg)
            begin
                prod_reg <= '0;
            end
            else
            begin
                prod_reg <= feature * $signed(rdata_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= rd_en;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    assign prod       = prod_reg;
    assign prod_valid = prod_valid_reg;

endmodule

`default_nettype wire

>>> sv/lpas_scan.sv
// ---------------------------------------------------------------------------
// lpas_scan
// Argmax over the ring with randomized tie break. Each action has a
// sample step (ring shifts, difference registered), each after the first a decide step.
// ---------------------------------------------------------------------------
`default_nettype none

module lpas_scan
    import lpas_pkg::*;
#(
    parameter int NUM_ACTIONS = 4
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] cand,
    input  wire logic [TOL_W-1:0]        tol,
    input  wire logic [RND_W-1:0]        rnd,
    output logic                         shift,
    output logic                         done,
    output scan_res_t                    res
);

    localparam logic [ACT_W-1:0] LAST_ACT = ACT_W'(NUM_ACTIONS - 1);

    logic                     busy_reg;
    logic                     decide_reg;
    logic [ACT_W-1:0]         cnt_reg;
    logic signed [ACC_W-1:0]  best_reg;
    logic [ACT_W-1:0]         best_idx_reg;
    logic [ACT_W-1:0]         ties_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic signed [ACC_W-1:0]  cand_reg;

    logic [ACT_W-1:0]         act_m1;
    logic [SLICE_W-1:0]       slice;
    logic [ACT_W-1:0]         ties_inc;
    logic [ACT_W-1:0]         tie_mul;
    logic [SLICE_W+ACT_W-1:0] scaled;
    logic signed [DIFF_W-1:0] tol_pos;
    logic signed [DIFF_W-1:0] tol_neg;
    logic                     is_tie;
    logic                     take_tie;

    always_comb
    begin
        act_m1   = cnt_reg - ACT_W'(1);
        slice    = rnd[{act_m1[1:0], 4'b0000} +: SLICE_W];
        ties_inc = ties_reg + ACT_W'(1);
        // replace with probability 1/(1+ties), ties counting this one
        tie_mul  = ties_reg + ACT_W'(2);
        scaled   = slice * tie_mul;
        tol_pos  = $signed({(DIFF_W-TOL_W)'(0), tol});
        tol_neg  = -tol_pos;
        is_tie   = (d_reg < tol_pos) && (d_reg > tol_neg);
        take_tie = (scaled[SLICE_W+ACT_W-1:SLICE_W] == '0);
    end

    assign shift = busy_reg && !decide_reg;
    assign done  = busy_reg && decide_reg && (cnt_reg == LAST_ACT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            decide_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            decide_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (!decide_reg)
            begin
                // first action only loads the best, no decide cycle
                if (cnt_reg == '0)
                begin
                    cnt_reg <= ACT_W'(1);
                end
                else
                begin
                    decide_reg <= 1'b1;
                end
            end
            else
            begin
                decide_reg <= 1'b0;
                cnt_reg    <= cnt_reg + ACT_W'(1);
                if (cnt_reg == LAST_ACT)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !decide_reg)
        begin
            if (cnt_reg == '0)
            begin
                best_reg     <= cand;
                best_idx_reg <= '0;
                ties_reg     <= '0;
            end
            else
            begin
                d_reg    <= {cand[ACC_W-1], cand} - {best_reg[ACC_W-1], best_reg};
                cand_reg <= cand;
            end
        end
        else if (busy_reg && decide_reg)
        begin
            if (is_tie)
            begin
                ties_reg <= ties_inc;
                if (take_tie)
                begin
                    best_reg     <= cand_reg;
                    best_idx_reg <= cnt_reg;
                end
            end
            else if (d_reg > 0)
            begin
                best_reg     <= cand_reg;
                best_idx_reg <= cnt_reg;
                ties_reg     <= '0;
            end
        end
    end

    always_comb
    begin
        res.action = best_idx_reg;
        res.score  = best_reg;
        res.ties   = ties_reg;
    end

endmodule

`default_nettype wire

>>> sv/linear_policy_action_select.sv
// ---------------------------------------------------------------------------
// linear_policy_action_select
// Linear action scoring with argmax and randomized tie break.
// ---------------------------------------------------------------------------
// A weight beat writes one table slot. In a feature beat the weight table
// has one read port, so the weights of the actions are read one per cycle,
// multiplied, and added into a ring of NUM_ACTIONS accumulator cells that
// rotates once per product. A beat with tlast set, also a feature past
// NUM_FEATURES, then scans the ring, clearing it, and hands the result to
// the output register once that register is free. The block takes one beat
// at a time; the output register lets the next beat in while a result waits.
// Weight slots that were never written give undefined scores.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_policy_action_select
    import lpas_pkg::*;
#(
    parameter int NUM_ACTIONS  = 4,
    parameter int NUM_FEATURES = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,   // tie_tolerance
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // weight_index[5:0], weight_value[21:6], feature_value[37:22],
    // random_word[101:38], zero pad[103:102]
    input  wire logic [103:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,  // feature_last
    input  wire logic         s_axis_tuser,  // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // chosen_action[2:0], best_score[42:3], tie_count[45:43], zero pad[47:46]
    output logic [47:0]       m_axis_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [ADDR_W-1:0] NF_STEP  = ADDR_W'(NUM_FEATURES);
    localparam logic [POS_W-1:0]  NF_POS   = POS_W'(NUM_FEATURES);
    localparam logic [ACT_W-1:0]  LAST_ACT = ACT_W'(NUM_ACTIONS - 1);
    localparam logic [ACT_W-1:0]  NA_CNT   = ACT_W'(NUM_ACTIONS);

    logic [1:0]              state_reg, state_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ACT_W-1:0]        iss_reg, iss_next;
    logic [ACT_W-1:0]        shcnt_reg, shcnt_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [TOL_W-1:0]        tol_reg;
    logic signed [W_W-1:0]   fval_reg;
    logic [RND_W-1:0]        rnd_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    scan_res_t               out_reg;

    logic                    s_acc;
    logic                    is_write;
    logic                    do_mac;
    logic                    rd_en;
    logic                    mac_done;
    logic                    scan_start;
    logic                    out_load;
    logic                    ring_shift;

    logic signed [PROD_W-1:0] prod;
    logic                     prod_valid;
    logic                     scan_shift;
    logic                     scan_done;
    scan_res_t                scan_res;

    logic signed [ACC_W-1:0] acc    [NUM_ACTIONS];
    logic signed [ACC_W-1:0] tail_nbr;
    logic signed [ACC_W-1:0] tail_add;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign is_write      = (s_axis_tuser == OP_WRITE);
    assign do_mac        = (pos_reg < NF_POS);
    assign rd_en         = (state_reg == ST_MAC) && (iss_reg < NA_CNT);
    assign mac_done      = prod_valid && (shcnt_reg == LAST_ACT);
    assign scan_start    = (s_acc && !is_write && !do_mac && s_axis_tlast)
                         || (mac_done && last_reg);
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign ring_shift    = prod_valid || scan_shift;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        iss_next   = iss_reg;
        shcnt_next = shcnt_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && !is_write)
                begin
                    if (do_mac)
                    begin
                        state_next = ST_MAC;
                        iss_next   = '0;
                        shcnt_next = '0;
                        addr_next  = {{(ADDR_W-POS_W){1'b0}}, pos_reg};
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_MAC:
            begin
                if (rd_en)
                begin
                    iss_next  = iss_reg + ACT_W'(1);
                    addr_next = addr_reg + NF_STEP;
                end
                if (prod_valid)
                begin
                    shcnt_next = shcnt_reg + ACT_W'(1);
                end
                if (mac_done)
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = last_reg ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            iss_reg       <= '0;
            shcnt_reg     <= '0;
            tol_reg       <= TOL_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            iss_reg   <= iss_next;
            shcnt_reg <= shcnt_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (s_acc)
        begin
            fval_reg <= $signed(s_axis_tdata[37:22]);
            rnd_reg  <= s_axis_tdata[101:38];
            last_reg <= s_axis_tlast;
        end
        if (out_load)
        begin
            out_reg <= scan_res;
        end
    end

    lpas_weight_mac u_wmac (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (s_acc && is_write),
        .wr_slot    (s_axis_tdata[5:0]),
        .wr_data    (s_axis_tdata[21:6]),
        .rd_en      (rd_en),
        .rd_addr    (addr_reg),
        .feature    (fval_reg),
        .prod       (prod),
        .prod_valid (prod_valid)
    );

    // the tail takes the head plus the product; a scan feeds zeros to clear
    assign tail_nbr = scan_shift ? '0 : acc[0];
    assign tail_add = scan_shift ? '0 : {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    for (genvar i = 0; i < NUM_ACTIONS; i++)
    begin : g_ring
        if (i == NUM_ACTIONS - 1)
        begin : g_tail
            lpas_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (ring_shift),
                .nbr_in (tail_nbr),
                .addend (tail_add),
                .acc    (acc[i])
            );
        end
        else
        begin : g_body
            lpas_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (ring_shift),
                .nbr_in (acc[i+1]),
                .addend ('0),
                .acc    (acc[i])
            );
        end
    end

    lpas_scan #(
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .cand  (acc[0]),
        .tol   (tol_reg),
        .rnd   (rnd_reg),
        .shift (scan_shift),
        .done  (scan_done),
        .res   (scan_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.ties, out_reg.score, out_reg.action};

    a_ring_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ring_shift)
        else $error("accumulator ring rotates while idle");

    a_prod_in_mac : assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> (state_reg == ST_MAC))
        else $error("product arrives outside a feature update");

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= NF_POS)
        else $error("feature position past the feature count");

    a_out_from_scan : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result posted without a finished scan");

    a_scan_only_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        scan_shift |-> (state_reg == ST_SCAN))
        else $error("scan shifts the ring outside the scan state");

endmodule

`default_nettype wire
